>>> sv/nls_pkg.sv
// ---------------------------------------------------------------------------
// nls_pkg: shared types and constants for the nearest line segment search
// Segment record, register codes, commands, status codes and FSM states.
// ---------------------------------------------------------------------------
package nls_pkg;

  localparam int COORD_W    = 24;
  localparam int DIR_W      = 16;
  localparam int ANG_W      = 16;
  localparam int LEN_W      = 25;
  localparam int AGATE_W    = 14;
  localparam int OGATE_W    = 23;
  localparam int FRAC_W     = 16;
  localparam int WGT_W      = 16;
  localparam int SCORE_W    = 41;
  localparam int MIDX_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int HALF_TURN    = 25736;
  localparam int QUARTER_TURN = 12868;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MATCH   = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_ANGLE_GATE  = 3'd0,
    REG_OFFSET_GATE = 3'd1,
    REG_OVERLAP     = 3'd2,
    REG_ANGLE_WGT   = 3'd3,
    REG_OFFSET_WGT  = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [COORD_W-1:0] p2x;
    logic signed [COORD_W-1:0] p2y;
    logic signed [DIR_W-1:0]   dx;
    logic signed [DIR_W-1:0]   dy;
    logic signed [ANG_W-1:0]   ang;
    logic [LEN_W-1:0]          len;
  } seg_t;

  typedef struct packed {
    logic [AGATE_W-1:0] angle_gate;
    logic [OGATE_W-1:0] offset_gate;
    logic [FRAC_W-1:0]  overlap_frac;
    logic [WGT_W-1:0]   angle_wgt;
    logic [WGT_W-1:0]   offset_wgt;
  } cfg_t;

endpackage

>>> sv/nls_in_if.sv
// ---------------------------------------------------------------------------
// nls_in_if: command and segment channel
// Valid/ready channel carrying one command with its segment.
// ---------------------------------------------------------------------------
interface nls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [23:0] seg_p1_x;
  logic [23:0] seg_p1_y;
  logic [23:0] seg_p2_x;
  logic [23:0] seg_p2_y;
  logic [15:0] seg_dir_x;
  logic [15:0] seg_dir_y;
  logic [15:0] seg_angle;
  logic [24:0] seg_length;

  modport source (output valid, cmd, seg_p1_x, seg_p1_y, seg_p2_x, seg_p2_y,
                  seg_dir_x, seg_dir_y, seg_angle, seg_length, input ready);
  modport sink (input valid, cmd, seg_p1_x, seg_p1_y, seg_p2_x, seg_p2_y,
                seg_dir_x, seg_dir_y, seg_angle, seg_length, output ready);
endinterface

>>> sv/nls_out_if.sv
// ---------------------------------------------------------------------------
// nls_out_if: result channel
// Valid/ready channel carrying status, match index and match score.
// ---------------------------------------------------------------------------
interface nls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  match_index;
  logic [40:0] match_score;

  modport source (output valid, status, match_index, match_score, input ready);
  modport sink (input valid, status, match_index, match_score, output ready);
endinterface

>>> sv/nearest_line_segment_search.sv
// ---------------------------------------------------------------------------
// nearest_line_segment_search: nearest stored line segment lookup
// Segment table held in a ring of cells, scanned by a scoring pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries a command with a segment: load appends it to the table,
//   clear empties the table, query searches it. out_o returns one result
//   per command: status, best index and best score.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the gate and weight registers;
//   write them only while the block is idle.
//   Load, clear and unused commands leave the block idle, so it takes the next
//   command at once while the output register holds a free slot.
//   A query rotates the whole ring once, one entry per cycle into the
//   scoring pipeline, so the ring length and not the number of loaded
//   entries sets its duration. Commands are not taken during a query.
//   Reset empties the table and loads the default register values.
//   When the receiver stalls, the result waits in the output register and
//   a finished query waits for the slot before the block goes idle.
// ---------------------------------------------------------------------------
module nearest_line_segment_search #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  nls_in_if.sink                             in_i,
  nls_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [nls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nls_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IXW   = (IDX_W > nls_pkg::MIDX_W) ? IDX_W : nls_pkg::MIDX_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  nls_pkg::state_e state_q, state_d;
  nls_pkg::cfg_t   cfg_q;
  nls_pkg::seg_t   in_seg, qry_q;
  nls_pkg::seg_t   ring [TABLE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d, scan_q, scan_d;
  logic             accept, emit, slot_free, issue, full;
  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [40:0]      best_q, best_d;
  logic             out_vld_q, out_vld_d;
  logic [1:0]       out_stat_q, out_stat_d;
  logic [5:0]       out_idx_q, out_idx_d;
  logic [40:0]      out_score_q, out_score_d;
  logic [IXW-1:0]   best_wide;
  logic             busy, res_act, res_pass;
  logic [IDX_W-1:0] res_idx;
  logic [40:0]      res_score;

  assign in_seg = '{p1x: in_i.seg_p1_x, p1y: in_i.seg_p1_y,
                    p2x: in_i.seg_p2_x, p2y: in_i.seg_p2_y,
                    dx: in_i.seg_dir_x, dy: in_i.seg_dir_y,
                    ang: in_i.seg_angle, len: in_i.seg_length};

  assign slot_free = !out_vld_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign issue     = (state_q == nls_pkg::S_SCAN);
  assign full      = (count_q >= DEPTH_C);

  // ring of table cells, head at index zero
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nls_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (accept && (nls_pkg::cmd_e'(in_i.cmd) == nls_pkg::CMD_LOAD)
                   && !full && (count_q == CNT_W'(i))),
      .load_seg_i (in_seg),
      .shift_i    (issue),
      .nbr_seg_i  (ring[(i + 1) % TABLE_DEPTH]),
      .seg_o      (ring[i])
    );
  end

  nls_eval #(.IDX_W(IDX_W)) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_i       (issue),
    .use_i       (scan_q < count_q),
    .idx_i       (scan_q[IDX_W-1:0]),
    .ent_i       (ring[0]),
    .qry_i       (qry_q),
    .cfg_i       (cfg_q),
    .busy_o      (busy),
    .res_act_o   (res_act),
    .res_pass_o  (res_pass),
    .res_idx_o   (res_idx),
    .res_score_o (res_score)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nls_pkg::S_IDLE: begin
        if (accept && (nls_pkg::cmd_e'(in_i.cmd) == nls_pkg::CMD_QUERY)) begin
          state_d = nls_pkg::S_SCAN;
        end
      end
      nls_pkg::S_SCAN: begin
        if (scan_q == DEPTH_C - CNT_W'(1)) begin
          state_d = nls_pkg::S_DRAIN;
        end
      end
      nls_pkg::S_DRAIN: begin
        if (!busy) begin
          state_d = nls_pkg::S_DONE;
        end
      end
      nls_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = nls_pkg::S_IDLE;
        end
      end
      default: state_d = nls_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_i.ready  = (state_q == nls_pkg::S_IDLE) && slot_free;
    emit        = 1'b0;
    count_d     = count_q;
    scan_d      = scan_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_stat_d  = out_stat_q;
    out_idx_d   = out_idx_q;
    out_score_d = out_score_q;
    best_wide   = IXW'(best_idx_q);
    unique case (state_q)
      nls_pkg::S_IDLE: begin
        if (accept) begin
          emit        = 1'b1;
          out_stat_d  = nls_pkg::STAT_OK;
          out_idx_d   = '0;
          out_score_d = '0;
          scan_d      = '0;
          found_d     = 1'b0;
          unique case (nls_pkg::cmd_e'(in_i.cmd))
            nls_pkg::CMD_LOAD: begin
              if (full) begin
                out_stat_d = nls_pkg::STAT_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            nls_pkg::CMD_CLEAR: count_d = '0;
            nls_pkg::CMD_QUERY: emit = 1'b0;
            default: ;
          endcase
        end
      end
      nls_pkg::S_SCAN: scan_d = scan_q + CNT_W'(1);
      nls_pkg::S_DRAIN: ;
      nls_pkg::S_DONE: begin
        if (slot_free) begin
          emit        = 1'b1;
          out_stat_d  = found_q ? nls_pkg::STAT_MATCH : nls_pkg::STAT_NOMATCH;
          out_idx_d   = found_q ? best_wide[5:0] : '0;
          out_score_d = found_q ? best_q : '0;
        end
      end
      default: ;
    endcase
    if (res_act && res_pass && (!found_q || (res_score < best_q))) begin
      found_d    = 1'b1;
      best_d     = res_score;
      best_idx_d = res_idx;
    end
    if (emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nls_pkg::S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= '{angle_gate: 14'd12868, offset_gate: 23'd256,
                     overlap_frac: 16'd3277, angle_wgt: 16'd256,
                     offset_wgt: 16'd256};
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (nls_pkg::reg_e'(cfg_idx_i))
          nls_pkg::REG_ANGLE_GATE:  cfg_q.angle_gate   <= cfg_data_i[13:0];
          nls_pkg::REG_OFFSET_GATE: cfg_q.offset_gate  <= cfg_data_i;
          nls_pkg::REG_OVERLAP:     cfg_q.overlap_frac <= cfg_data_i[15:0];
          nls_pkg::REG_ANGLE_WGT:   cfg_q.angle_wgt    <= cfg_data_i[15:0];
          nls_pkg::REG_OFFSET_WGT:  cfg_q.offset_wgt   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    out_stat_q  <= out_stat_d;
    out_idx_q   <= out_idx_d;
    out_score_q <= out_score_d;
    if (accept) begin
      qry_q <= in_seg;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_stat_q;
  assign out_o.match_index = out_idx_q;
  assign out_o.match_score = out_score_q;

endmodule

>>> sv/nls_cell.sv
// ---------------------------------------------------------------------------
// nls_cell: one table entry of the segment ring
// Holds a segment; loads it from the input or takes the neighbor's entry.
// ---------------------------------------------------------------------------
module nls_cell (
  input  logic          clk_i,
  input  logic          load_i,
  input  nls_pkg::seg_t load_seg_i,
  input  logic          shift_i,
  input  nls_pkg::seg_t nbr_seg_i,
  output nls_pkg::seg_t seg_o
);

  nls_pkg::seg_t seg_q, seg_d;

  always_comb begin
    seg_d = seg_q;
    if (load_i) begin
      seg_d = load_seg_i;
    end else if (shift_i) begin
      seg_d = nbr_seg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign seg_o = seg_q;

endmodule

>>> sv/nls_eval.sv
// ---------------------------------------------------------------------------
// nls_eval: pair gate and score pipeline
// Four stages: angle wrap and differences, products, gates, weighted score.
// ---------------------------------------------------------------------------
module nls_eval #(
  parameter int IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             act_i,
  input  logic             use_i,
  input  logic [IDX_W-1:0] idx_i,
  input  nls_pkg::seg_t    ent_i,
  input  nls_pkg::seg_t    qry_i,
  input  nls_pkg::cfg_t    cfg_i,
  output logic             busy_o,
  output logic             res_act_o,
  output logic             res_pass_o,
  output logic [IDX_W-1:0] res_idx_o,
  output logic [40:0]      res_score_o
);

  localparam logic signed [17:0] HT = 18'(nls_pkg::HALF_TURN);
  localparam logic signed [17:0] QT = 18'(nls_pkg::QUARTER_TURN);

  // stage 1
  logic signed [17:0] dif, d1, d2, d3;
  logic               act1_q, use1_q, lz1_q;
  logic [IDX_W-1:0]   idx1_q, idx2_q, idx3_q, idx4_q;
  logic [13:0]        ang1_d, ang1_q, ang2_q;
  logic signed [25:0] kx1_q, ky1_q;
  logic signed [15:0] dirx1_q, diry1_q, sdx1_q, sdy1_q;
  logic signed [24:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic [24:0]        mn1_q;
  logic [38:0]        top1_q, top2_q;
  // stage 2
  logic               act2_q, use2_q, lz2_q;
  logic signed [41:0] cx2_q, cy2_q;
  logic signed [40:0] t1x2_q, t1y2_q, t2x2_q, t2y2_q;
  logic [29:0]        ap2_q;
  logic [40:0]        need2_q;
  // stage 3
  logic signed [42:0] cr;
  logic [42:0]        acr;
  logic [27:0]        offw;
  logic signed [41:0] t1, t2;
  logic [38:0]        c1, c2, ov;
  logic               pass3_d;
  logic               act3_q, pass3_q;
  logic [22:0]        off3_q;
  logic [24:0]        at3_q;
  // stage 4
  logic               act4_q, pass4_q;
  logic [40:0]        score4_q;

  always_comb begin
    dif = 18'(ent_i.ang) - 18'(qry_i.ang);
    d1  = (dif <= -QT) ? dif + HT : ((dif > QT) ? dif - HT : dif);
    d2  = (d1 <= -QT) ? d1 + HT : ((d1 > QT) ? d1 - HT : d1);
    d3  = (d2 <= -QT) ? d2 + HT : ((d2 > QT) ? d2 - HT : d2);
    ang1_d = (d3 < 0) ? 14'(-d3) : 14'(d3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act1_q <= 1'b0;
      act2_q <= 1'b0;
      act3_q <= 1'b0;
      act4_q <= 1'b0;
    end else begin
      act1_q <= act_i;
      act2_q <= act1_q;
      act3_q <= act2_q;
      act4_q <= act3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    use1_q  <= use_i;
    idx1_q  <= idx_i;
    lz1_q   <= (ent_i.len == '0) || (qry_i.len == '0);
    ang1_q  <= ang1_d;
    kx1_q   <= 26'(ent_i.p1x) + 26'(ent_i.p2x) - 26'(qry_i.p1x) - 26'(qry_i.p2x);
    ky1_q   <= 26'(ent_i.p1y) + 26'(ent_i.p2y) - 26'(qry_i.p1y) - 26'(qry_i.p2y);
    dirx1_q <= (ent_i.len > qry_i.len) ? ent_i.dx : qry_i.dx;
    diry1_q <= (ent_i.len > qry_i.len) ? ent_i.dy : qry_i.dy;
    sdx1_q  <= ent_i.dx;
    sdy1_q  <= ent_i.dy;
    ax1_q   <= 25'(qry_i.p1x) - 25'(ent_i.p1x);
    ay1_q   <= 25'(qry_i.p1y) - 25'(ent_i.p1y);
    bx1_q   <= 25'(qry_i.p2x) - 25'(ent_i.p1x);
    by1_q   <= 25'(qry_i.p2y) - 25'(ent_i.p1y);
    mn1_q   <= (ent_i.len < qry_i.len) ? ent_i.len : qry_i.len;
    top1_q  <= {ent_i.len, 14'd0};

    use2_q  <= use1_q;
    idx2_q  <= idx1_q;
    lz2_q   <= lz1_q;
    ang2_q  <= ang1_q;
    top2_q  <= top1_q;
    cx2_q   <= 42'(kx1_q) * 42'(diry1_q);
    cy2_q   <= 42'(ky1_q) * 42'(dirx1_q);
    t1x2_q  <= 41'(sdx1_q) * 41'(ax1_q);
    t1y2_q  <= 41'(sdy1_q) * 41'(ay1_q);
    t2x2_q  <= 41'(sdx1_q) * 41'(bx1_q);
    t2y2_q  <= 41'(sdy1_q) * 41'(by1_q);
    ap2_q   <= 30'(cfg_i.angle_wgt) * 30'(ang1_q);
    need2_q <= 41'(cfg_i.overlap_frac) * 41'(mn1_q);

    idx3_q  <= idx2_q;
    pass3_q <= pass3_d;
    off3_q  <= offw[22:0];
    at3_q   <= ap2_q[29:5];

    idx4_q   <= idx3_q;
    pass4_q  <= pass3_q;
    score4_q <= 41'(at3_q) + 41'(cfg_i.offset_wgt) * 41'(off3_q);
  end

  always_comb begin
    cr   = 43'(cx2_q) - 43'(cy2_q);
    acr  = (cr < 0) ? 43'(-cr) : 43'(cr);
    offw = 28'((acr + 43'd16384) >> 15);
    t1   = 42'(t1x2_q) + 42'(t1y2_q);
    t2   = 42'(t2x2_q) + 42'(t2y2_q);
    c1   = (t1 < 0) ? '0 : ((t1 > $signed({3'b000, top2_q})) ? top2_q : t1[38:0]);
    c2   = (t2 < 0) ? '0 : ((t2 > $signed({3'b000, top2_q})) ? top2_q : t2[38:0]);
    ov   = (c1 > c2) ? c1 - c2 : c2 - c1;
    pass3_d = use2_q && !lz2_q
           && (ang2_q <= cfg_i.angle_gate)
           && (offw <= 28'(cfg_i.offset_gate))
           && ((cfg_i.overlap_frac == '0) || (41'({ov, 1'b0}) >= need2_q));
  end

  assign busy_o      = act1_q | act2_q | act3_q | act4_q;
  assign res_act_o   = act4_q;
  assign res_pass_o  = pass4_q;
  assign res_idx_o   = idx4_q;
  assign res_score_o = score4_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for nearest_line_segment_search
// Loads, clears and queries segments over valid/ready channels with random
// gaps and stalls on both sides, predicts every result and checks it.
// ---------------------------------------------------------------------------
module tb;

  localparam int          DEPTH      = 64;
  localparam int          WDOG_LIMIT = 20000;
  localparam logic [2:0]  REG_SPARE  = 3'd5;
  localparam real         PI         = 3.14159265358979;

  typedef struct {
    nls_pkg::cmd_e cmd;
    nls_pkg::seg_t seg;
  } request_t;

  typedef struct {
    nls_pkg::status_e status;
    logic [5:0]       idx;
    logic [40:0]      score;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [nls_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [nls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  nls_in_if  in_if ();
  nls_out_if out_if ();

  nearest_line_segment_search #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  request_t       request_q[$];
  answer_t        answer_q[$];
  nls_pkg::seg_t  seg_table[DEPTH];
  int             n_entries = 0;
  nls_pkg::cfg_t  regs = '{angle_gate: 14'd12868, offset_gate: 23'd256,
                           overlap_frac: 16'd3277, angle_wgt: 16'd256,
                           offset_wgt: 16'd256};

  int unsigned n_offered = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_match = 0, n_nomatch = 0, n_full = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 1;
  int          snd_idle_pct = 20;
  int          rcv_idle_pct = 45;
  int          quiet_cycles = 0;

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(longint v, longint hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  function automatic answer_t search_step(nls_pkg::cmd_e c, nls_pkg::seg_t q);
    answer_t       r;
    nls_pkg::seg_t s;
    longint  d, kx, ky, dx, dy, cr, off, top, t1, t2, ov, mn, sc, best, slen, qlen;
    bit      found;
    r = '{nls_pkg::STAT_OK, '0, '0};
    found = 1'b0;
    best = 0;
    case (c)
      nls_pkg::CMD_LOAD: begin
        if (n_entries >= DEPTH) begin
          r.status = nls_pkg::STAT_FULL;
        end else begin
          seg_table[n_entries] = q;
          n_entries++;
        end
      end
      nls_pkg::CMD_CLEAR: n_entries = 0;
      nls_pkg::CMD_QUERY: begin
        for (int i = 0; i < n_entries; i++) begin
          s = seg_table[i];
          slen = longint'(s.len);
          qlen = longint'(q.len);
          if (slen == 0 || qlen == 0) continue;
          d = longint'($signed(s.ang)) - longint'($signed(q.ang));
          while (d <= -nls_pkg::QUARTER_TURN) d += nls_pkg::HALF_TURN;
          while (d > nls_pkg::QUARTER_TURN) d -= nls_pkg::HALF_TURN;
          d = iabs(d);
          if (d > longint'(regs.angle_gate)) continue;
          kx = longint'($signed(s.p1x)) + longint'($signed(s.p2x))
             - longint'($signed(q.p1x)) - longint'($signed(q.p2x));
          ky = longint'($signed(s.p1y)) + longint'($signed(s.p2y))
             - longint'($signed(q.p1y)) - longint'($signed(q.p2y));
          dx = (slen > qlen) ? longint'($signed(s.dx)) : longint'($signed(q.dx));
          dy = (slen > qlen) ? longint'($signed(s.dy)) : longint'($signed(q.dy));
          cr = kx * dy - ky * dx;
          off = (iabs(cr) + 16384) >>> 15;
          if (off > longint'(regs.offset_gate)) continue;
          if (regs.overlap_frac != 0) begin
            top = slen << 14;
            t1 = longint'($signed(s.dx)) * (longint'($signed(q.p1x)) - longint'($signed(s.p1x)))
               + longint'($signed(s.dy)) * (longint'($signed(q.p1y)) - longint'($signed(s.p1y)));
            t2 = longint'($signed(s.dx)) * (longint'($signed(q.p2x)) - longint'($signed(s.p1x)))
               + longint'($signed(s.dy)) * (longint'($signed(q.p2y)) - longint'($signed(s.p1y)));
            ov = iabs(clip(t1, top) - clip(t2, top));
            mn = slen < qlen ? slen : qlen;
            if (ov * 2 < longint'(regs.overlap_frac) * mn) continue;
          end
          sc = ((longint'(regs.angle_wgt) * d) >>> 5) + longint'(regs.offset_wgt) * off;
          if (!found || sc < best) begin
            found = 1'b1;
            best = sc;
            r.idx = i[5:0];
          end
        end
        if (found) begin
          r.status = nls_pkg::STAT_MATCH;
          r.score = best[40:0];
        end else begin
          r.status = nls_pkg::STAT_NOMATCH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: hold the offer until transfer, then advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (n_offered == n_taken) begin
      if (request_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        request_t r;
        r = request_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.cmd        <= r.cmd;
        in_if.seg_p1_x   <= r.seg.p1x;
        in_if.seg_p1_y   <= r.seg.p1y;
        in_if.seg_p2_x   <= r.seg.p2x;
        in_if.seg_p2_y   <= r.seg.p2y;
        in_if.seg_dir_x  <= r.seg.dx;
        in_if.seg_dir_y  <= r.seg.dy;
        in_if.seg_angle  <= r.seg.ang;
        in_if.seg_length <= r.seg.len;
        n_offered <= n_offered + 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!hold_done && n_taken >= 150) begin
      hold_done <= 1'b1;
      hold_cnt  <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    logic    any;
    any = 1'b0;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          nls_pkg::REG_ANGLE_GATE:  regs.angle_gate   = cfg_data[nls_pkg::AGATE_W-1:0];
          nls_pkg::REG_OFFSET_GATE: regs.offset_gate  = cfg_data[nls_pkg::OGATE_W-1:0];
          nls_pkg::REG_OVERLAP:     regs.overlap_frac = cfg_data[nls_pkg::FRAC_W-1:0];
          nls_pkg::REG_ANGLE_WGT:   regs.angle_wgt    = cfg_data[nls_pkg::WGT_W-1:0];
          nls_pkg::REG_OFFSET_WGT:  regs.offset_wgt   = cfg_data[nls_pkg::WGT_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        nls_pkg::seg_t s;
        answer_t       pred;
        s = '{p1x: in_if.seg_p1_x, p1y: in_if.seg_p1_y, p2x: in_if.seg_p2_x,
              p2y: in_if.seg_p2_y, dx: in_if.seg_dir_x, dy: in_if.seg_dir_y,
              ang: in_if.seg_angle, len: in_if.seg_length};
        pred = search_step(nls_pkg::cmd_e'(in_if.cmd), s);
        answer_q = {answer_q, pred};
        n_taken <= n_taken + 1;
        any = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        any = 1'b1;
        got = '{nls_pkg::status_e'(out_if.status), out_if.match_index,
                out_if.match_score};
        n_results++;
        case (got.status)
          nls_pkg::STAT_MATCH:   n_match++;
          nls_pkg::STAT_NOMATCH: n_nomatch++;
          nls_pkg::STAT_FULL:    n_full++;
          default: ;
        endcase
        if (answer_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result status=%0d", got.status);
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status || got.idx !== want.idx ||
              got.score !== want.score) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d exp st=%0d idx=%0d sc=%0d got st=%0d idx=%0d sc=%0d",
                       n_results, want.status, want.idx, want.score,
                       got.status, got.idx, got.score);
          end
        end
      end
      quiet_cycles <= any ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  nls_pkg::seg_t gen_list[$];
  int            n_gen = 0;

  task automatic push(nls_pkg::cmd_e c, nls_pkg::seg_t s);
    request_t r;
    r.cmd = c;
    r.seg = s;
    request_q = {request_q, r};
    n_gen++;
    if (c == nls_pkg::CMD_CLEAR) gen_list.delete();
    if (c == nls_pkg::CMD_LOAD) gen_list = {gen_list, s};
  endtask

  function automatic nls_pkg::seg_t make_seg(real x0, real y0, real a, int unsigned len);
    nls_pkg::seg_t s;
    int            ai;
    while (a > PI) a -= 2.0 * PI;
    while (a <= -PI) a += 2.0 * PI;
    ai = int'(a * 8192.0);
    if (ai > nls_pkg::HALF_TURN) ai = nls_pkg::HALF_TURN;
    if (ai < -nls_pkg::HALF_TURN) ai = -nls_pkg::HALF_TURN;
    s.p1x = 24'(int'(x0));
    s.p1y = 24'(int'(y0));
    s.p2x = 24'(int'(x0 + $cos(a) * len));
    s.p2y = 24'(int'(y0 + $sin(a) * len));
    s.dx  = 16'(int'($cos(a) * 16384.0));
    s.dy  = 16'(int'($sin(a) * 16384.0));
    s.ang = 16'(ai);
    s.len = 25'(len);
    return s;
  endfunction

  function automatic nls_pkg::seg_t noise_seg();
    nls_pkg::seg_t s;
    logic [191:0]  raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    s = raw[$bits(nls_pkg::seg_t)-1:0];
    return s;
  endfunction

  function automatic real rnd(int span);
    return real'($signed($urandom_range(2 * span) - span));
  endfunction

  function automatic nls_pkg::seg_t near_seg(nls_pkg::seg_t b);
    real a, mx, my, l;
    a  = real'($signed(b.ang)) / 8192.0 + rnd(400) / 8192.0
       + (($urandom_range(9) == 0) ? PI : 0.0);
    l  = real'(b.len) * (0.5 + real'($urandom_range(100)) / 100.0) + 1.0;
    mx = (real'($signed(b.p1x)) + real'($signed(b.p2x))) / 2.0 + rnd(300);
    my = (real'($signed(b.p1y)) + real'($signed(b.p2y))) / 2.0 + rnd(300);
    return make_seg(mx - $cos(a) * l / 2.0, my - $sin(a) * l / 2.0, a, int'(l));
  endfunction

  function automatic nls_pkg::seg_t good_seg();
    return make_seg(rnd(1 << 18), rnd(1 << 18), rnd(3141) / 1000.0,
                    $urandom_range(256, 1 << 16));
  endfunction

  task automatic fill_burst();
    push(nls_pkg::CMD_CLEAR, noise_seg());
    for (int i = 0; i < DEPTH + 3; i++) push(nls_pkg::CMD_LOAD, good_seg());
    for (int i = 0; i < 3; i++)
      push(nls_pkg::CMD_QUERY, near_seg(gen_list[$urandom_range(DEPTH - 1)]));
  endtask

  task automatic random_block(int n);
    int target, k;
    target = n_gen + n;
    while (n_gen < target) begin
      k = $urandom_range(99);
      if (k < 8) begin
        push(nls_pkg::cmd_e'($urandom_range(3)), noise_seg());
      end else begin
        if (k < 30 || gen_list.size() > 40) push(nls_pkg::CMD_CLEAR, noise_seg());
        repeat ($urandom_range(1, 8)) push(nls_pkg::CMD_LOAD, good_seg());
        repeat ($urandom_range(1, 4))
          push(nls_pkg::CMD_QUERY, near_seg(gen_list[$urandom_range(gen_list.size() - 1)]));
      end
    end
  endtask

  task automatic drain();
    wait (request_q.size() == 0 && n_offered == n_taken && answer_q.size() == 0);
    repeat (DEPTH + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_regs(int ag, int og, int ovl, int aw, int ow);
    write_reg(nls_pkg::REG_ANGLE_GATE, 23'(ag));
    write_reg(nls_pkg::REG_OFFSET_GATE, 23'(og));
    write_reg(nls_pkg::REG_OVERLAP, 23'(ovl));
    write_reg(nls_pkg::REG_ANGLE_WGT, 23'(aw));
    write_reg(nls_pkg::REG_OFFSET_WGT, 23'(ow));
    n_settings++;
  endtask

  initial begin
    nls_pkg::seg_t s, z;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, zero lengths, extremes, every command
    z = '0;
    push(nls_pkg::CMD_QUERY, good_seg());
    s = make_seg(0.0, 0.0, 0.3, 5000);
    push(nls_pkg::CMD_LOAD, s);
    push(nls_pkg::CMD_QUERY, s);
    s.len = '0;
    push(nls_pkg::CMD_QUERY, s);
    push(nls_pkg::CMD_LOAD, z);
    push(nls_pkg::CMD_QUERY, make_seg(0.0, 0.0, 0.3, 5000));
    push(nls_pkg::CMD_LOAD, '{p1x: 24'sh7FFFFF, p1y: 24'sh800000, p2x: 24'sh800000,
                              p2y: 24'sh7FFFFF, dx: 16'sd16384, dy: -16'sd16384,
                              ang: 16'sd25736, len: 25'h1FFFFFF});
    push(nls_pkg::CMD_QUERY, '{p1x: 24'sh800000, p1y: 24'sh7FFFFF, p2x: 24'sh7FFFFF,
                               p2y: 24'sh800000, dx: -16'sd16384, dy: 16'sd16384,
                               ang: -16'sd25736, len: 25'h1FFFFFF});
    push(nls_pkg::CMD_LOAD, make_seg(100.0, 100.0, PI, 3000));
    push(nls_pkg::CMD_QUERY, make_seg(100.0, 100.0, -PI + 0.001, 3000));
    push(nls_pkg::CMD_NONE, noise_seg());
    push(nls_pkg::CMD_CLEAR, noise_seg());
    push(nls_pkg::CMD_QUERY, s);
    push(nls_pkg::CMD_LOAD, make_seg(0.0, 0.0, 1.0, 4000));
    push(nls_pkg::CMD_LOAD, make_seg(0.0, 0.0, 1.0, 4000));
    push(nls_pkg::CMD_QUERY, make_seg(0.0, 0.0, 1.0, 4000));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 45 : 0;
      rcv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 20 : 0;
      case (ph)
        0: begin
          random_block(130);
          drain();
          set_regs(12868, 8388607, 32768, 65535, 65535);
          write_reg(REG_SPARE, 23'($urandom()));
        end
        1: begin
          set_regs(0, 0, 0, 0, 0);
          fill_burst();
          random_block(60);
          drain();
          set_regs(3000, 2000, 0, 1000, 300);
        end
        default: begin
          set_regs($urandom_range(12868), $urandom_range(4000), $urandom_range(32768),
                   $urandom(), $urandom());
          random_block(140);
          drain();
          set_regs(12868, 1000, 16384, 65535, 1);
        end
      endcase
      random_block(140);
      drain();
    end

    $display("covered %0d transfers under %0d register settings", n_taken, n_settings);
    $display("results: %0d match, %0d no match, %0d dropped on full table, %0d errors",
             n_match, n_nomatch, n_full, n_errors);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
